@@ hw/rtl/mrc_pkg.sv @@
// Shared types, codes and the CRC-16 byte step for the Modbus RTU request and reply check unit.
package mrc_pkg;

	// Operation codes of an input word
	typedef enum logic [1:0] {
		OP_SEND  = 2'd0,
		OP_RX    = 2'd1,
		OP_END   = 2'd2,
		OP_SPARE = 2'd3
	} op_t;

	// Reply check phase
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SEARCH = 2'd1,
		PH_FRAME  = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	// Check status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_ADDR   = 3'd1;
	localparam logic [2:0] ST_FUNCTION  = 3'd2;
	localparam logic [2:0] ST_ECHO      = 3'd3;
	localparam logic [2:0] ST_COUNT     = 3'd4;
	localparam logic [2:0] ST_CRC       = 3'd5;
	localparam logic [2:0] ST_UNSUPPORT = 3'd6;
	localparam logic [2:0] ST_SHORT     = 3'd7;

	// Output word kinds
	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_RESULT = 1'b1;

	// Modbus constants
	localparam logic [7:0]  FC_READ    = 8'h03;
	localparam logic [7:0]  FC_WRITE   = 8'h06;
	localparam logic [7:0]  READ_COUNT = 8'h04;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;

	// Default scan bound on received bytes
	localparam int RX_LIMIT_DEF = 20;

	// Command queue depth between front and back
	localparam int CMD_DEPTH = 4;

	// Command handed from front to back
	typedef struct packed {
		logic        is_result;
		logic [7:0]  slave;
		logic [7:0]  func;
		logic [15:0] addr;
		logic [15:0] value;
		logic [2:0]  status;
		logic [31:0] result;
	} cmd_t;

	// One byte step of the reflected Modbus CRC-16
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/modbus_rtu_request_and_reply_check_unit.sv @@
// Top level of the Modbus RTU request builder and reply checker.
// Throughput: one input word per cycle while the queue has room; a send word yields eight
// output words at one per cycle while popped, set by the single frame serializer, so
// back-to-back sends are paced by that stage. Words pass the queue, then an output register.
// Reply bytes and end words are checked in the cycle they are accepted.
// Reset: arst_n clears queue, checker and output valid at once; no clearing pass.
module modbus_rtu_request_and_reply_check_unit #(
	parameter int RX_LIMIT = mrc_pkg::RX_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  operation,
	input  logic [7:0]  slave_address,
	input  logic [7:0]  function_code,
	input  logic [15:0] register_address,
	input  logic [15:0] register_value,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic [2:0]  status,
	output logic signed [31:0] reply_value
);
	import mrc_pkg::*;

	logic accept;
	logic cmd_push, cmd_pop, cmd_full, cmd_empty;
	cmd_t cmd_in, cmd_head;

	// Accept a word while the command queue has room
	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	mrc_front #(
		.RX_LIMIT(RX_LIMIT)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.operation        (operation),
		.slave_address    (slave_address),
		.function_code    (function_code),
		.register_address (register_address),
		.register_value   (register_value),
		.rx_byte          (rx_byte),
		.cmd_push         (cmd_push),
		.cmd_data         (cmd_in)
	);

	mrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.pop       (cmd_pop),
		.full      (cmd_full),
		.empty     (cmd_empty),
		.head      (cmd_head)
	);

	mrc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_empty   (cmd_empty),
		.cmd_head    (cmd_head),
		.cmd_pop     (cmd_pop),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind),
		.tx_byte     (tx_byte),
		.last        (last),
		.status      (status),
		.reply_value (reply_value)
	);

endmodule

@@ hw/rtl/mrc_front.sv @@
// Front part: takes input words, tracks the reply check and queues frame and result commands.
module mrc_front #(
	parameter int RX_LIMIT = mrc_pkg::RX_LIMIT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [1:0]    operation,
	input  logic [7:0]    slave_address,
	input  logic [7:0]    function_code,
	input  logic [15:0]   register_address,
	input  logic [15:0]   register_value,
	input  logic [7:0]    rx_byte,
	output logic          cmd_push,
	output mrc_pkg::cmd_t cmd_data
);
	import mrc_pkg::*;

	localparam int CW = $clog2(RX_LIMIT + 1);

	phase_t      phase_q, phase_d;
	logic [3:0]  pos_q, pos_d;
	logic [15:0] crc_q, crc_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  fail_q, fail_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [7:0]  req_slave_q, req_func_q;
	logic [15:0] req_addr_q, req_value_q;

	op_t         op;
	logic [15:0] crc_step;
	logic [7:0]  echo_byte;

	assign op = op_t'(operation);

	// CRC step over the received byte; a new reply starts from the init value
	assign crc_step = crc_byte((phase_q == PH_SEARCH) ? CRC_INIT : crc_q, rx_byte);

	// Expected echo byte for the write reply
	always_comb begin
		case (pos_q)
			4'd2:    echo_byte = req_addr_q[15:8];
			4'd3:    echo_byte = req_addr_q[7:0];
			4'd4:    echo_byte = req_value_q[15:8];
			4'd5:    echo_byte = req_value_q[7:0];
			4'd6:    echo_byte = crc_q[7:0];
			default: echo_byte = crc_q[15:8];
		endcase
	end

	// Next state of the checker and queue command
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		crc_d    = crc_q;
		acc_d    = acc_q;
		fail_d   = fail_q;
		cnt_d    = cnt_q;
		cmd_push = 1'b0;
		cmd_data = '0;
		if (accept) begin
			case (op)
				OP_SEND: begin
					cmd_push           = 1'b1;
					cmd_data.is_result = 1'b0;
					cmd_data.slave     = slave_address;
					cmd_data.func      = function_code;
					cmd_data.addr      = register_address;
					cmd_data.value     = register_value;
					phase_d = PH_SEARCH;
					pos_d   = '0;
					crc_d   = CRC_INIT;
					acc_d   = '0;
					fail_d  = ST_OK;
					cnt_d   = '0;
				end
				OP_END: begin
					cmd_push           = 1'b1;
					cmd_data.is_result = 1'b1;
					if (phase_q == PH_DONE) begin
						cmd_data.status = fail_q;
						cmd_data.result = (fail_q == ST_OK) ? acc_q : 32'd0;
					end else if (phase_q == PH_FRAME) begin
						cmd_data.status = ST_SHORT;
					end else begin
						cmd_data.status = ST_NO_ADDR;
					end
					phase_d = PH_IDLE;
					pos_d   = '0;
					crc_d   = CRC_INIT;
					acc_d   = '0;
					fail_d  = ST_OK;
					cnt_d   = '0;
				end
				OP_RX: begin
					if ((phase_q == PH_SEARCH || phase_q == PH_FRAME) &&
					    cnt_q < CW'(RX_LIMIT)) begin
						cnt_d = cnt_q + 1'b1;
						if (phase_q == PH_SEARCH) begin
							// hunt for the slave address
							if (rx_byte == req_slave_q) begin
								crc_d   = crc_step;
								pos_d   = 4'd1;
								acc_d   = '0;
								phase_d = PH_FRAME;
							end
						end else if (pos_q == 4'd1) begin
							// function code check
							if (rx_byte != req_func_q) begin
								fail_d  = ST_FUNCTION;
								acc_d   = '0;
								phase_d = PH_DONE;
							end else if (req_func_q != FC_READ && req_func_q != FC_WRITE) begin
								crc_d   = crc_step;
								fail_d  = ST_UNSUPPORT;
								acc_d   = '0;
								phase_d = PH_DONE;
							end else begin
								crc_d = crc_step;
								pos_d = 4'd2;
							end
						end else if (req_func_q == FC_WRITE) begin
							// echo compare; CRC over a correct echo equals the request CRC
							if (rx_byte != echo_byte) begin
								fail_d  = ST_ECHO;
								acc_d   = '0;
								phase_d = PH_DONE;
							end else if (pos_q >= 4'd7) begin
								fail_d  = ST_OK;
								acc_d   = {16'd0, req_value_q};
								phase_d = PH_DONE;
							end else begin
								if (pos_q <= 4'd5) begin
									crc_d = crc_step;
								end
								pos_d = pos_q + 1'b1;
							end
						end else begin
							// read reply: count, data, CRC
							if (pos_q == 4'd2) begin
								if (rx_byte != READ_COUNT) begin
									fail_d  = ST_COUNT;
									acc_d   = '0;
									phase_d = PH_DONE;
								end else begin
									crc_d = crc_step;
									pos_d = pos_q + 1'b1;
								end
							end else if (pos_q <= 4'd6) begin
								crc_d = crc_step;
								acc_d = {acc_q[23:0], rx_byte};
								pos_d = pos_q + 1'b1;
							end else if (pos_q == 4'd7) begin
								if (rx_byte != crc_q[7:0]) begin
									fail_d  = ST_CRC;
									acc_d   = '0;
									phase_d = PH_DONE;
								end else begin
									pos_d = pos_q + 1'b1;
								end
							end else begin
								if (rx_byte != crc_q[15:8]) begin
									fail_d  = ST_CRC;
									acc_d   = '0;
								end else begin
									fail_d  = ST_OK;
								end
								phase_d = PH_DONE;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Hold checker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			crc_q   <= CRC_INIT;
			acc_q   <= '0;
			fail_q  <= ST_OK;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			crc_q   <= crc_d;
			acc_q   <= acc_d;
			fail_q  <= fail_d;
			cnt_q   <= cnt_d;
		end
	end

	// Store the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_slave_q <= '0;
			req_func_q  <= '0;
			req_addr_q  <= '0;
			req_value_q <= '0;
		end else if (accept && op == OP_SEND) begin
			req_slave_q <= slave_address;
			req_func_q  <= function_code;
			req_addr_q  <= register_address;
			req_value_q <= register_value;
		end
	end

endmodule

@@ hw/rtl/mrc_queue.sv @@
// Short command queue between the front and back parts.
module mrc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mrc_pkg::cmd_t push_data,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output mrc_pkg::cmd_t head
);
	import mrc_pkg::*;

	localparam int AW = $clog2(CMD_DEPTH);

	cmd_t        mem_q [CMD_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == (AW+1)'(CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Write entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(CMD_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(CMD_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/mrc_back.sv @@
// Back part: serializes request frames with their CRC and presents result words.
module mrc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  mrc_pkg::cmd_t cmd_head,
	output logic          cmd_pop,
	input  logic          pop,
	output logic          empty,
	output logic          kind,
	output logic [7:0]    tx_byte,
	output logic          last,
	output logic [2:0]    status,
	output logic signed [31:0] reply_value
);
	import mrc_pkg::*;

	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic        out_free, step;
	logic [7:0]  frame_byte;
	logic [15:0] crc_next;
	logic        kind_q;
	logic [7:0]  tx_byte_q;
	logic        last_q;
	logic [2:0]  status_q;
	logic signed [31:0] reply_value_q;

	assign out_free = !out_valid_q || pop;
	assign step     = !cmd_empty && out_free;
	assign cmd_pop  = step && (cmd_head.is_result || idx_q == 3'd7);
	assign empty    = !out_valid_q;

	assign kind        = kind_q;
	assign tx_byte     = tx_byte_q;
	assign last        = last_q;
	assign status      = status_q;
	assign reply_value = reply_value_q;

	// Select the frame byte in wire order
	always_comb begin
		case (idx_q)
			3'd0:    frame_byte = cmd_head.slave;
			3'd1:    frame_byte = cmd_head.func;
			3'd2:    frame_byte = cmd_head.addr[15:8];
			3'd3:    frame_byte = cmd_head.addr[7:0];
			3'd4:    frame_byte = cmd_head.value[15:8];
			3'd5:    frame_byte = cmd_head.value[7:0];
			3'd6:    frame_byte = crc_q[7:0];
			default: frame_byte = crc_q[15:8];
		endcase
	end

	assign crc_next = crc_byte((idx_q == 3'd0) ? CRC_INIT : crc_q, frame_byte);

	// Advance byte index and running frame CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= CRC_INIT;
		end else if (step && !cmd_head.is_result) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q <= 3'd5) begin
				crc_q <= crc_next;
			end
		end
	end

	// Hold the output word until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load output payload
	always_ff @(posedge clk) begin
		if (step) begin
			if (cmd_head.is_result) begin
				kind_q        <= KIND_RESULT;
				tx_byte_q     <= 8'd0;
				last_q        <= 1'b1;
				status_q      <= cmd_head.status;
				reply_value_q <= cmd_head.result;
			end else begin
				kind_q        <= KIND_TX;
				tx_byte_q     <= frame_byte;
				last_q        <= (idx_q == 3'd7);
				status_q      <= ST_OK;
				reply_value_q <= '0;
			end
		end
	end

endmodule
